@@ rtl/core/running_average_background_subtract_assert.svh @@
// Assertion macros shared by the background subtraction RTL
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RABS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rabs check failed");

// next-cycle implication, checked out of reset
`define RABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rabs check failed");

`endif

@@ rtl/core/rabs_pkg.sv @@
// Shared types and constants for the running average background subtractor
package rabs_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int POS_W      = 19;
  localparam int FP_W       = 20;
  localparam int FRAC_BITS  = 8;
  localparam int BG_W       = 8 + FRAC_BITS;
  localparam int ALPHA_W    = 9;
  localparam int THR_W      = 8;
  localparam int PIX_W      = 8;
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;

  localparam logic [13:0] W_RED   = 14'd4899;
  localparam logic [13:0] W_GREEN = 14'd9617;
  localparam logic [13:0] W_BLUE  = 14'd1868;
  localparam logic [13:0] GRAY_RND = 14'd8192;

  localparam logic [BG_W-1:0] BG_MAX  = BG_W'(255 << FRAC_BITS);
  localparam logic [BG_W-1:0] BG_HALF = BG_W'(1 << (FRAC_BITS - 1));

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);
  localparam int                 ALPHA_FRAC = 8;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(20);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(77);
  localparam logic [FP_W-1:0]    FP_RESET    = FP_W'(307200);

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ALPHA     = 2'd1;
  localparam logic [1:0] REG_FRAME_PIX = 2'd2;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [BG_W-1:0]  data;
  } bg_wr_t;

endpackage

@@ rtl/core/running_average_background_subtract.sv @@
// Top level of the running average background subtractor
//
//   port group | dir | contents
//   in_*       | in  | one BGR pixel word per valid/ready handshake
//   out_*      | out | foreground flag, abs difference, end of frame marker
//   cfg_*      | in  | register write: threshold, alpha, frame size
//
// One pixel word per cycle unless out stalls; accepted pixels pass the compute stage,
// then the output register behind out_valid. One read and one write of the background
// memory per pixel; a write meeting a same-word read in the same cycle is forwarded.
// Synchronous reset clears control state only; the memory is not cleared, the
// first frame after reset loads it instead.
// A stalled output holds the compute stage, which then holds off the input.
module running_average_background_subtract
  import rabs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_blue,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_red,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_foreground,
  output logic [7:0]       out_abs_difference,
  output logic             out_last_of_frame,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [FP_W-1:0]  cfg_wdata
);

  `include "running_average_background_subtract_assert.svh"

  localparam int DIFF_W = BG_W + 2;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int NB_W   = BG_W + 3;
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1 << (ALPHA_FRAC - 1));

  // configuration
  logic [THR_W-1:0]   thr_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [FP_W-1:0]    fpix_r;

  // frame tracking
  logic [POS_W-1:0] pos_r;
  logic             bg_ready_r;

  // compute stage
  logic             s1_v_r;
  logic [7:0]       s1_gray_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_last_r;
  logic             s1_learn_r;
  logic             byp_r;
  logic [BG_W-1:0]  byp_data_r;

  // output register
  logic       out_v_r;
  logic [7:0] out_fg_r;
  logic [7:0] out_ad_r;
  logic       out_last_r;
  logic [16:0] out_word;

  logic                    s1_adv;
  logic                    in_fire;
  logic [FP_W-1:0]         fp_eff;
  logic                    in_last;
  logic [GRAY_SUM_W-1:0]   gray_sum;
  logic [7:0]              in_gray;
  logic [BG_W-1:0]         rd_data;
  logic [BG_W-1:0]         bg_cur;
  logic [BG_W:0]           bg_rnd;
  logic [7:0]              b8;
  logic [7:0]              ad;
  logic [7:0]              fg;
  logic [ALPHA_W-1:0]      alpha_eff;
  logic [BG_W-1:0]         gray_fix;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] diff_x;
  logic signed [PROD_W-1:0] alpha_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] delta_w;
  logic signed [DIFF_W-1:0] delta;
  logic signed [NB_W-1:0]   nb;
  logic [BG_W-1:0]          bg_upd;
  logic [BG_W-1:0]          new_bg;
  bg_wr_t                   bg_wr;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    priority if (fpix_r == '0) begin
      fp_eff = FP_W'(1);
    end else if (fpix_r > FP_W'(MAX_PIXELS)) begin
      fp_eff = FP_W'(MAX_PIXELS);
    end else begin
      fp_eff = fpix_r;
    end
  end

  assign in_last = {1'b0, pos_r} >= (fp_eff - FP_W'(1));

  assign gray_sum = GRAY_SUM_W'(W_RED) * GRAY_SUM_W'(in_red)
                  + GRAY_SUM_W'(W_GREEN) * GRAY_SUM_W'(in_green)
                  + GRAY_SUM_W'(W_BLUE) * GRAY_SUM_W'(in_blue)
                  + GRAY_SUM_W'(GRAY_RND);
  assign in_gray  = gray_sum[GRAY_SHIFT +: 8];

  // compare and update
  assign bg_cur = byp_r ? byp_data_r : rd_data;
  assign bg_rnd = {1'b0, bg_cur} + (BG_W + 1)'(BG_HALF);
  assign b8     = (bg_rnd[BG_W:FRAC_BITS] > 9'd255) ? 8'hFF : bg_rnd[FRAC_BITS +: 8];
  assign ad     = (s1_gray_r > b8) ? (s1_gray_r - b8) : (b8 - s1_gray_r);
  assign fg     = (ad > thr_r) ? 8'hFF : 8'h00;

  assign alpha_eff = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
  assign gray_fix  = {s1_gray_r, {FRAC_BITS{1'b0}}};
  assign diff      = $signed({2'b00, gray_fix}) - $signed({2'b00, bg_cur});
  assign diff_x    = PROD_W'(diff);
  assign alpha_x   = $signed({{(PROD_W - ALPHA_W){1'b0}}, alpha_eff});
  assign prod      = diff_x * alpha_x;
  assign prod_rnd  = prod + PROD_HALF;
  assign delta_w   = prod_rnd >>> ALPHA_FRAC;
  assign delta     = delta_w[DIFF_W-1:0];
  assign nb        = NB_W'(delta) + $signed({3'b000, bg_cur});

  always_comb begin
    priority if (nb < 0) begin
      bg_upd = '0;
    end else if (nb > $signed({3'b000, BG_MAX})) begin
      bg_upd = BG_MAX;
    end else begin
      bg_upd = nb[BG_W-1:0];
    end
  end

  assign new_bg = s1_learn_r ? bg_upd : gray_fix;

  assign bg_wr.en   = s1_adv;
  assign bg_wr.addr = s1_pos_r;
  assign bg_wr.data = new_bg;

  rabs_bg_ram u_bg_ram (
    .clk     (clk),
    .wr      (bg_wr),
    .rd_en   (in_fire),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      alpha_r <= ALPHA_RESET;
      fpix_r  <= FP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r   <= cfg_wdata[THR_W-1:0];
        REG_ALPHA:     alpha_r <= cfg_wdata[ALPHA_W-1:0];
        REG_FRAME_PIX: fpix_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      bg_ready_r <= 1'b0;
      s1_v_r     <= 1'b0;
      byp_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_last) begin
          pos_r      <= '0;
          bg_ready_r <= 1'b1;
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
        byp_r <= s1_adv && (s1_pos_r == pos_r);
      end
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_gray_r  <= in_gray;
      s1_pos_r   <= pos_r;
      s1_last_r  <= in_last;
      s1_learn_r <= bg_ready_r;
      byp_data_r <= new_bg;
    end
    if (s1_adv) begin
      out_fg_r   <= s1_learn_r ? fg : 8'h00;
      out_ad_r   <= s1_learn_r ? ad : 8'h00;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_foreground     = out_fg_r;
  assign out_abs_difference = out_ad_r;
  assign out_last_of_frame  = out_last_r;
  assign out_word           = {out_fg_r, out_ad_r, out_last_r};

  `RABS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, s1_v_r && !s1_adv, !in_ready)
  `RABS_ASSERT_NEXT(a_last_wraps_pos, clk, rst_n, in_fire && in_last, pos_r == '0)
  `RABS_ASSERT_NOW(a_bg_in_range, clk, rst_n, bg_wr.en, bg_wr.data <= BG_MAX)
  `RABS_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

@@ rtl/core/rabs_bg_ram.sv @@
// Background store: one write port, one registered read port
module rabs_bg_ram
  import rabs_pkg::*;
(
  input  logic             clk,
  input  bg_wr_t           wr,
  input  logic             rd_en,
  input  logic [POS_W-1:0] rd_addr,
  output logic [BG_W-1:0]  rd_data
);

  logic [BG_W-1:0] mem [MAX_PIXELS];
  logic [BG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
